// File: design/dve_pkg.sv
package dve_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CPB_W       = 11;
    localparam int KEY_W       = 64;
    localparam int KLEN_W      = 5;

    localparam logic [4:0]  MOD_BASE     = 5'd26;
    localparam logic [7:0]  LETTER_A     = 8'h61;
    localparam logic [11:0] RECIP_26     = 12'd2521;
    localparam int          RECIP_SHIFT  = 16;

    typedef enum logic [1:0] {
        CFG_CHIPS_PER_BIT = 2'd0,
        CFG_KEY_LOW_CHARS = 2'd1,
        CFG_KEY_HIGH_CHARS = 2'd2,
        CFG_KEY_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          chip_positive;
        logic                          first_sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic [7:0] plain_byte;
        logic       text_ended;
    } out_item_t;

    // completed byte handed from despreader to decryptor
    typedef struct packed {
        logic [7:0] raw_byte;
        logic [7:0] key_char;
        logic       ended;
    } byte_req_t;

endpackage

// File: design/dve_despread.sv
module dve_despread #(
    parameter int MAX_CHIPS_PER_BIT = 1024,
    parameter int MAX_KEY_CHARS     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  dve_pkg::in_item_t             item,
    input  logic [dve_pkg::CPB_W-1:0]     chips_per_bit,
    input  logic [dve_pkg::KEY_W-1:0]     key_low_chars,
    input  logic [dve_pkg::KEY_W-1:0]     key_high_chars,
    input  logic [dve_pkg::KLEN_W-1:0]    key_length,
    output logic                          byte_valid,
    output dve_pkg::byte_req_t            byte_req
);
    import dve_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_CHIPS_PER_BIT) + 1;
    localparam int CNT_W = $clog2(MAX_CHIPS_PER_BIT + 1);
    localparam int EFF_W = (CNT_W > CPB_W) ? CNT_W : CPB_W;
    localparam int KI_W  = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
    localparam logic [EFF_W-1:0]  MAX_CHIPS = EFF_W'(MAX_CHIPS_PER_BIT);
    localparam logic [KLEN_W-1:0] MAX_LEN   = KLEN_W'(MAX_KEY_CHARS);

    logic [SUM_W-1:0] sum_reg, sum_next, sum_base, sum_new, sample_ext;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_base, cnt_inc;
    logic [7:0]       shift_reg, shift_next, shift_base, shift_new;
    logic [2:0]       bitcnt_reg, bitcnt_next, bitcnt_base;
    logic [KI_W-1:0]  ki_reg, ki_next, ki_base;
    logic [KI_W:0]    ki_inc;
    logic             ended_reg, ended_next, ended_base, ended_new;
    logic [EFF_W-1:0] eff_chips;
    logic [KLEN_W-1:0] eff_len;
    logic             bit_val, bit_done, byte_done;
    logic [2*KEY_W-1:0] key_all;
    logic [7:0]       key_bytes [MAX_KEY_CHARS];

    assign key_all = {key_high_chars, key_low_chars};

    for (genvar g = 0; g < MAX_KEY_CHARS; g++) begin : g_key
        assign key_bytes[g] = key_all[8*g +: 8];
    end

    always_comb
    begin
        if (chips_per_bit == '0)
            eff_chips = EFF_W'(1);
        else if (EFF_W'(chips_per_bit) > MAX_CHIPS)
            eff_chips = MAX_CHIPS;
        else
            eff_chips = EFF_W'(chips_per_bit);

        if (key_length == '0)
            eff_len = KLEN_W'(1);
        else if (key_length > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = key_length;
    end

    always_comb
    begin
        sum_base    = item.first_sample ? '0 : sum_reg;
        cnt_base    = item.first_sample ? '0 : cnt_reg;
        shift_base  = item.first_sample ? '0 : shift_reg;
        bitcnt_base = item.first_sample ? '0 : bitcnt_reg;
        ki_base     = item.first_sample ? '0 : ki_reg;
        ended_base  = item.first_sample ? 1'b0 : ended_reg;

        sample_ext = {{(SUM_W-SAMPLE_BITS){item.sample[SAMPLE_BITS-1]}}, item.sample};
        sum_new    = item.chip_positive ? sum_base + sample_ext : sum_base - sample_ext;
        cnt_inc    = cnt_base + 1'b1;
        bit_done   = EFF_W'(cnt_inc) >= eff_chips;
        bit_val    = !sum_new[SUM_W-1] && (sum_new != '0);
        shift_new  = {shift_base[6:0], bit_val};
        byte_done  = bit_done && (bitcnt_base == 3'd7);
        ended_new  = ended_base || (shift_new == 8'd0);
        ki_inc     = {1'b0, ki_base} + 1'b1;

        sum_next    = bit_done ? '0 : sum_new;
        cnt_next    = bit_done ? '0 : cnt_inc;
        bitcnt_next = bit_done ? bitcnt_base + 3'd1 : bitcnt_base;
        shift_next  = byte_done ? 8'd0 : (bit_done ? shift_new : shift_base);
        ended_next  = byte_done ? ended_new : ended_base;
        ki_next     = ki_base;
        if (byte_done && !ended_new)
            ki_next = (KLEN_W'(ki_inc) >= eff_len) ? '0 : ki_inc[KI_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            cnt_reg    <= '0;
            shift_reg  <= '0;
            bitcnt_reg <= '0;
            ki_reg     <= '0;
            ended_reg  <= 1'b0;
        end
        else if (accept)
        begin
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            bitcnt_reg <= bitcnt_next;
            ki_reg     <= ki_next;
            ended_reg  <= ended_next;
        end
    end

    assign byte_valid        = accept && byte_done;
    assign byte_req.raw_byte = shift_new;
    assign byte_req.key_char = key_bytes[ki_base];
    assign byte_req.ended    = ended_new;

endmodule

// File: design/dve_decrypt.sv
module dve_decrypt (
    input  dve_pkg::byte_req_t  byte_req,
    output dve_pkg::out_item_t  result
);
    import dve_pkg::*;

    logic [9:0]  diff;
    logic [8:0]  mag;
    logic [20:0] prod;
    logic [4:0]  quot;
    logic [8:0]  rem_full;
    logic [4:0]  rem;
    logic [7:0]  dec;

    // (c - k + 26) rem 26, truncating toward zero; |c - k + 26| <= 281
    always_comb
    begin
        diff     = {{2{byte_req.raw_byte[7]}}, byte_req.raw_byte}
                 - {{2{byte_req.key_char[7]}}, byte_req.key_char}
                 + 10'(MOD_BASE);
        mag      = diff[9] ? 9'(-diff) : diff[8:0];
        prod     = 21'(mag) * 21'(RECIP_26);
        quot     = prod[RECIP_SHIFT +: 5];
        rem_full = mag - 9'(quot) * 9'(MOD_BASE);
        rem      = rem_full[4:0];
        dec      = diff[9] ? LETTER_A - 8'(rem) : LETTER_A + 8'(rem);
    end

    assign result.raw_byte   = byte_req.raw_byte;
    assign result.plain_byte = byte_req.ended ? byte_req.raw_byte : dec;
    assign result.text_ended = byte_req.ended;

endmodule

// File: design/dsss_despread_vigenere_extract_top.sv
// A byte's result is registered in the byte register, then decrypted into the output register.
// Throughput: one sample per cycle while in_stall is low; one result per 8 * chips_per_bit samples.
// in_stall rises only while both the byte register and the output register hold requests.
// Reset: asynchronous, active low; clears all counters, the sum, the end flag and both
// output-side valids; configuration returns to chips_per_bit 8, zero key, key_length 1.
module dsss_despread_vigenere_extract_top #(
    parameter int MAX_CHIPS_PER_BIT = 1024,
    parameter int MAX_KEY_CHARS     = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  dve_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output dve_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [dve_pkg::KEY_W-1:0]   cfg_data
);
    import dve_pkg::*;

    logic [CPB_W-1:0]  chips_reg;
    logic [KEY_W-1:0]  key_low_reg, key_high_reg;
    logic [KLEN_W-1:0] key_len_reg;
    logic              accept, byte_valid, pend_move, out_free;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;
    byte_req_t         byte_req, pend_reg;
    out_item_t         dec_result, out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chips_reg    <= CPB_W'(8);
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KLEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CHIPS_PER_BIT:  chips_reg    <= cfg_data[CPB_W-1:0];
                CFG_KEY_LOW_CHARS:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH_CHARS: key_high_reg <= cfg_data;
                CFG_KEY_LENGTH:     key_len_reg  <= cfg_data[KLEN_W-1:0];
                default:            key_len_reg  <= key_len_reg;
            endcase
        end
    end

    assign in_stall  = pend_valid_reg && out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pend_move = pend_valid_reg && out_free;

    dve_despread #(
        .MAX_CHIPS_PER_BIT (MAX_CHIPS_PER_BIT),
        .MAX_KEY_CHARS     (MAX_KEY_CHARS)
    ) u_despread (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .item           (in_data),
        .chips_per_bit  (chips_reg),
        .key_low_chars  (key_low_reg),
        .key_high_chars (key_high_reg),
        .key_length     (key_len_reg),
        .byte_valid     (byte_valid),
        .byte_req       (byte_req)
    );

    dve_decrypt u_decrypt (
        .byte_req (pend_reg),
        .result   (dec_result)
    );

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (byte_valid)
            pend_valid_next = 1'b1;
        else if (pend_move)
            pend_valid_next = 1'b0;
        out_valid_next = pend_move || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid)
            pend_reg <= byte_req;
        if (pend_move)
            out_reg <= dec_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a held byte request is never overwritten before it moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !pend_move |-> !byte_valid)
        else $error("byte request overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.raw_byte == 8'd0) |-> out_reg.text_ended)
        else $error("zero byte without end flag");

    // decrypted bytes land in 'a' +/- 25
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.text_ended |->
            (out_reg.plain_byte >= 8'd72) && (out_reg.plain_byte <= 8'd122))
        else $error("decrypted byte out of range");

endmodule

// File: bench/dve_checker.sv
`timescale 1ns / 1ps
module dve_checker #(
    parameter int MAX_CHIPS_PER_BIT = 1024,
    parameter int MAX_KEY_CHARS     = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  dve_pkg::in_item_t           in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  dve_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [dve_pkg::KEY_W-1:0]   cfg_data,
    output int                          errors,
    output int                          bytes_owed
);
    import dve_pkg::*;

    logic [CPB_W-1:0]  chips_cfg;
    logic [KEY_W-1:0]  key_lo;
    logic [KEY_W-1:0]  key_hi;
    logic [KLEN_W-1:0] key_len_cfg;

    int         corr;
    int         chip_count;
    logic [7:0] bits;
    int         bit_count;
    int         key_pos;
    logic       text_done;

    out_item_t  expected_bytes[$];
    out_item_t  want;

    task automatic restart_message();
        corr       = 0;
        chip_count = 0;
        bits       = '0;
        bit_count  = 0;
        key_pos    = 0;
        text_done  = 1'b0;
    endtask

    task automatic despread_sample(input in_item_t it);
        int         span;
        int         key_span;
        int         diff;
        logic [7:0] key_char;
        out_item_t  res;
        if (it.first_sample)
            restart_message();
        if (it.chip_positive)
            corr += int'($signed(it.sample));
        else
            corr -= int'($signed(it.sample));
        if (chips_cfg == 0)
            span = 1;
        else if (chips_cfg > MAX_CHIPS_PER_BIT)
            span = MAX_CHIPS_PER_BIT;
        else
            span = int'(chips_cfg);
        chip_count++;
        if (chip_count < span)
            return;
        bits       = {bits[6:0], corr > 0};
        corr       = 0;
        chip_count = 0;
        bit_count++;
        if (bit_count < 8)
            return;
        bit_count    = 0;
        res.raw_byte = bits;
        bits         = '0;
        if (res.raw_byte == 8'h00)
            text_done = 1'b1;
        if (text_done)
        begin
            res.plain_byte = res.raw_byte;
        end
        else
        begin
            key_char = (key_pos < 8) ? key_lo[8*key_pos +: 8] : key_hi[8*(key_pos-8) +: 8];
            diff = (int'($signed(res.raw_byte)) - int'($signed(key_char)) + int'(MOD_BASE))
                   % int'(MOD_BASE);
            res.plain_byte = 8'(diff + int'(LETTER_A));
            if (key_len_cfg == 0)
                key_span = 1;
            else if (key_len_cfg > MAX_KEY_CHARS)
                key_span = MAX_KEY_CHARS;
            else
                key_span = int'(key_len_cfg);
            key_pos++;
            if (key_pos >= key_span)
                key_pos = 0;
        end
        res.text_ended = text_done;
        expected_bytes.push_back(res);
    endtask

    task automatic note_mismatch(input string field, input int exp_val, input int got_val);
        errors++;
        if (errors <= 100)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chips_cfg   = 8;
            key_lo      = '0;
            key_hi      = '0;
            key_len_cfg = 1;
            restart_message();
            expected_bytes.delete();
            errors     = 0;
            bytes_owed = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CHIPS_PER_BIT:  chips_cfg = cfg_data[CPB_W-1:0];
                    CFG_KEY_LOW_CHARS:  key_lo = cfg_data;
                    CFG_KEY_HIGH_CHARS: key_hi = cfg_data;
                    CFG_KEY_LENGTH:     key_len_cfg = cfg_data[KLEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                despread_sample(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    if (errors <= 100)
                        $display("%0t: unexpected byte, expected none, actual %h/%h/%b",
                                 $time, out_data.raw_byte, out_data.plain_byte,
                                 out_data.text_ended);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.raw_byte !== want.raw_byte)
                        note_mismatch("raw_byte", want.raw_byte, out_data.raw_byte);
                    if (out_data.plain_byte !== want.plain_byte)
                        note_mismatch("plain_byte", want.plain_byte, out_data.plain_byte);
                    if (out_data.text_ended !== want.text_ended)
                        note_mismatch("text_ended", want.text_ended, out_data.text_ended);
                end
            end
            bytes_owed = expected_bytes.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import dve_pkg::*;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [KEY_W-1:0]   cfg_data  = '0;

    int errors;
    int bytes_owed;

    int chips      = 8;
    int burst_left = 0;
    int items_sent = 0;
    int stall_mode = 0;
    int stall_left = 0;

    int dir_sample [26] = '{32767, -32768, -32768, 32767, 0, 1, -1, 0,
                            100, 5,
                            0, -7, -7, -7, -7, -7, -7, -7,
                            -5, 5, -5, 5, 5, -5, 5, -5};
    bit dir_chip [26]   = '{1, 1, 0, 0, 1, 1, 0, 0,
                            1, 0,
                            1, 1, 1, 1, 1, 1, 1, 1,
                            1, 1, 1, 1, 1, 1, 1, 1};

    dsss_despread_vigenere_extract_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dve_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .bytes_owed (bytes_owed)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("dsss_despread_vigenere_extract_top verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_left % 5) < 2);
        endcase
    end

    // chip whose contribution to the sum mostly carries the sign of the wanted bit; some are random or zero
    function automatic in_item_t chip_for(input bit b, input bit first);
        in_item_t it;
        int       mag;
        it.chip_positive = $urandom_range(0, 1);
        it.first_sample  = first;
        case ($urandom_range(0, 15))
            0:       it.sample = 16'($urandom);
            1:       it.sample = (b == it.chip_positive) ? 16'h7FFF : 16'h8000;
            2:       it.sample = '0;
            default:
            begin
                mag       = $urandom_range(1, 32767);
                it.sample = 16'((b == it.chip_positive) ? mag : -mag);
            end
        endcase
        return it;
    endfunction

    function automatic logic [7:0] message_char();
        if ($urandom_range(0, 1) == 0)
            return 8'h61 + 8'($urandom_range(0, 25));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 4))
            0: k = '1;
            1: k = '0;
            2:
            begin
                for (int i = 0; i < 8; i++)
                    k[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 25));
            end
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    task automatic send_item(input in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(100, 400);
            else
                burst_left = $urandom_range(0, 12);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input bit first);
        for (int j = 7; j >= 0; j--)
            for (int c = 0; c < chips; c++)
                send_item(chip_for(value[j], first && j == 7 && c == 0));
    endtask

    // hold off the sender until every predicted byte has come out
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (bytes_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [KEY_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_CHIPS_PER_BIT)
        begin
            if (value[CPB_W-1:0] == 0)
                chips = 1;
            else if (value[CPB_W-1:0] > 1024)
                chips = 1024;
            else
                chips = int'(value[CPB_W-1:0]);
        end
    endtask

    initial
    begin : stimulus
        in_item_t   it;
        logic [7:0] value;
        int         phase;
        int         phase_end;
        int         pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: chips 0 and key length 0 act as 1
        cfg_write(CFG_CHIPS_PER_BIT, 64'd0);
        cfg_write(CFG_KEY_LOW_CHARS, 64'h0102_7A61_417F_FF80);
        cfg_write(CFG_KEY_HIGH_CHARS, '1);
        cfg_write(CFG_KEY_LENGTH, 64'd0);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 26; i++)
        begin
            it.sample        = 16'(dir_sample[i]);
            it.chip_positive = dir_chip[i];
            it.first_sample  = (i == 0 || i == 10);
            send_item(it);
        end
        settle();

        // full-scale sum: one bit of most-negative samples at the largest span,
        // then the rest of the byte at one chip per bit
        cfg_write(CFG_CHIPS_PER_BIT, 64'h7FF);
        cfg_write(CFG_KEY_LENGTH, 64'd31);
        cfg_write(CFG_KEY_LOW_CHARS, pick_key());
        cfg_valid <= 1'b0;
        value = 8'($urandom_range(1, 254));
        for (int c = 0; c < chips; c++)
        begin
            it.sample        = 16'h8000;
            it.chip_positive = !value[7];
            it.first_sample  = (c == 0);
            send_item(it);
        end
        settle();
        cfg_write(CFG_CHIPS_PER_BIT, 64'd1);
        cfg_valid <= 1'b0;
        for (int j = 6; j >= 0; j--)
        begin
            it.sample        = 16'h8000;
            it.chip_positive = !value[j];
            it.first_sample  = 1'b0;
            send_item(it);
        end
        settle();

        phase = 0;
        while (items_sent < 1750)
        begin
            case (phase)
                0:       pick = 1;
                1:       pick = 0;
                default:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick <= 5)
                        pick = $urandom_range(1, 3);
                    else if (pick <= 8)
                        pick = $urandom_range(4, 10);
                    else
                        pick = 0;
                end
            endcase
            cfg_write(CFG_CHIPS_PER_BIT, 64'(pick));
            case (phase)
                0:       pick = 16;
                1:       pick = 31;
                2:       pick = 0;
                3:       pick = 17;
                default: pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(1, 16);
            endcase
            cfg_write(CFG_KEY_LENGTH, 64'(pick));
            if (phase < 2 || $urandom_range(0, 1) == 0)
                cfg_write(CFG_KEY_LOW_CHARS, pick_key());
            if (phase < 2 || $urandom_range(0, 1) == 0)
                cfg_write(CFG_KEY_HIGH_CHARS, pick_key());
            cfg_valid <= 1'b0;

            phase_end = items_sent + $urandom_range(60, 120);
            while (items_sent < phase_end)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        repeat ($urandom_range(1, 20))
                        begin
                            it.sample        = 16'($urandom);
                            it.chip_positive = $urandom_range(0, 1);
                            it.first_sample  = ($urandom_range(0, 15) == 0);
                            send_item(it);
                        end
                    end
                    1:
                    begin
                        // message cut short in the middle of a byte
                        send_byte(message_char(), 1'b1);
                        repeat ($urandom_range(1, 8 * chips - 1))
                            send_item(chip_for($urandom_range(0, 1), 1'b0));
                    end
                    default:
                    begin
                        pick = $urandom_range(1, 10);
                        for (int b = 0; b < pick; b++)
                            send_byte(message_char(), b == 0);
                        if ($urandom_range(0, 2) == 0)
                        begin
                            send_byte(8'h00, 1'b0);
                            repeat ($urandom_range(0, 3))
                                send_byte(message_char(), 1'b0);
                        end
                    end
                endcase
                if ($urandom_range(0, 19) == 0)
                    settle();
            end
            settle();
            phase++;
        end

        if (errors == 0 && bytes_owed == 0)
            $display("dsss_despread_vigenere_extract_top verification clean");
        else
            $display("dsss_despread_vigenere_extract_top verification failed");
        $finish;
    end

endmodule
